### hdl/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared constants for the perspective point projection pipeline.
// ----------------------------------------------------------------------------
package ppp_pkg;

  // default fixed-point formats
  localparam int COORD_FRAC_DEF = 16;
  localparam int TRIG_FRAC_DEF  = 14;

  // field widths
  localparam int COORD_W  = 32;
  localparam int TRIG_W   = 16;
  localparam int FOCAL_W  = 32;
  localparam int CENTER_W = 31;
  localparam int CFG_IDX_W = 3;

  // projected magnitude is capped at 2^QCAP_BITS
  localparam int QCAP_BITS = 40;
  // low slice width of the split magnitude multiply
  localparam int MUL_SPLIT = 20;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_TRIG    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_TRIG  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_SCALE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd7;

  // register reset values
  localparam logic [31:0]         RST_TRIG   = 32'h4000_0000;
  localparam logic [FOCAL_W-1:0]  RST_FOCAL  = 32'd27242660;
  localparam logic [CENTER_W-1:0] RST_CTR_X  = 31'd20971520;
  localparam logic [CENTER_W-1:0] RST_CTR_Y  = 31'd15728640;

endpackage

### hdl/ppp_rotate.sv
// ----------------------------------------------------------------------------
// ppp_rotate
// Two-stage plane rotation: a' = floor((a*c - b*s)/2^TF),
// b' = floor((a*s + b*c)/2^TF).
// ----------------------------------------------------------------------------
module ppp_rotate import ppp_pkg::*; #(
  parameter int AW = 36,
  parameter int TF = TRIG_FRAC_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic signed [AW-1:0]           in_a,
  input  logic signed [AW-1:0]           in_b,
  input  logic signed [TRIG_W-1:0]       in_cos,
  input  logic signed [TRIG_W-1:0]       in_sin,
  output logic                           out_valid,
  output logic signed [AW+TRIG_W-TF:0]   out_a,
  output logic signed [AW+TRIG_W-TF:0]   out_b
);

  localparam int PW = AW + TRIG_W;
  localparam int SW = PW + 1;

  logic                 v1_r, v2_r;
  logic signed [PW-1:0] pac_r, pbs_r, pas_r, pbc_r;
  logic signed [SW-1:0] da, db;
  logic signed [SW-TF-1:0] a_nxt, b_nxt, a_r, b_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  // stage 1: four products
  always_ff @(posedge clk) begin
    pac_r <= in_a * in_cos;
    pbs_r <= in_b * in_sin;
    pas_r <= in_a * in_sin;
    pbc_r <= in_b * in_cos;
  end

  // stage 2: sums, floor shift
  always_comb begin
    da    = {pac_r[PW-1], pac_r} - {pbs_r[PW-1], pbs_r};
    db    = {pas_r[PW-1], pas_r} + {pbc_r[PW-1], pbc_r};
    a_nxt = da[SW-1:TF];
    b_nxt = db[SW-1:TF];
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign out_valid = v2_r;
  assign out_a     = a_r;
  assign out_b     = b_r;

endmodule

### hdl/ppp_proj_div.sv
// ----------------------------------------------------------------------------
// ppp_proj_div
// Pipelined min(floor(mag*scale/den), 2^QCAP_BITS): split multiply, then a
// restoring divider with one quotient bit per stage.
// ----------------------------------------------------------------------------
module ppp_proj_div import ppp_pkg::*; #(
  parameter int MW = 36,
  parameter int NW = 39
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [MW-1:0]          in_mag,
  input  logic [FOCAL_W-1:0]     in_scale,
  input  logic [NW-1:0]          in_den,
  output logic                   out_valid,
  output logic [QCAP_BITS:0]     out_quot
);

  localparam int QB = QCAP_BITS;
  localparam int ML = MUL_SPLIT;
  localparam int MH = MW - ML;
  localparam int PW = MW + FOCAL_W;
  localparam int TW = PW - QB;
  localparam int CW = (TW > NW) ? TW : NW;
  localparam logic [QB:0] CAP = {1'b1, {QB{1'b0}}};

  // stage A: partial products
  logic                    va_r;
  logic [ML+FOCAL_W-1:0]   lo_r;
  logic [MH+FOCAL_W-1:0]   hi_r;
  logic [NW-1:0]           den_a_r;

  // stage B: full product
  logic                    vb_r;
  logic [PW-1:0]           prod_nxt, prod_r;
  logic [NW-1:0]           den_b_r;

  // stage C: overflow check and first remainder
  logic [CW-1:0]           topx, denx;
  logic                    ovf_nxt;
  logic [NW-1:0]           rem0_nxt;

  // divider stages
  logic                    v_r   [0:QB];
  logic                    ovf_r [0:QB];
  logic [NW-1:0]           rem_r [0:QB];
  logic [NW-1:0]           den_r [0:QB];
  logic [QB-1:0]           quo_r [0:QB];
  logic [QB-1:0]           low_r [0:QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= in_mag[ML-1:0] * in_scale;
    hi_r    <= in_mag[MW-1:ML] * in_scale;
    den_a_r <= in_den;
  end

  assign prod_nxt = {hi_r, {ML{1'b0}}} + PW'(lo_r);

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    den_b_r <= den_a_r;
  end

  // quotient reaches the cap when the high part alone holds den
  always_comb begin
    topx     = CW'(prod_r[PW-1:QB]);
    denx     = CW'(den_b_r);
    ovf_nxt  = (topx >= denx);
    rem0_nxt = ovf_nxt ? '0 : topx[NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    ovf_r[0] <= ovf_nxt;
    rem_r[0] <= rem0_nxt;
    den_r[0] <= den_b_r;
    quo_r[0] <= '0;
    low_r[0] <= prod_r[QB-1:0];
  end

  // one restoring step per stage
  for (genvar s = 0; s < QB; s++) begin : g_div
    logic [NW:0]   t;
    logic [NW:0]   diff;
    logic          ge;
    logic [NW-1:0] rem_nxt;

    always_comb begin
      t       = {rem_r[s], low_r[s][QB-1-s]};
      diff    = t - {1'b0, den_r[s]};
      ge      = (t >= {1'b0, den_r[s]});
      rem_nxt = ge ? diff[NW-1:0] : t[NW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      ovf_r[s+1] <= ovf_r[s];
      rem_r[s+1] <= rem_nxt;
      den_r[s+1] <= den_r[s];
      quo_r[s+1] <= {quo_r[s][QB-2:0], ge};
      low_r[s+1] <= low_r[s];
    end
  end

  assign out_valid = v_r[QB];
  assign out_quot  = ovf_r[QB] ? CAP : {1'b0, quo_r[QB]};

endmodule

### hdl/perspective_point_projection.sv
// ----------------------------------------------------------------------------
// perspective_point_projection
// Camera transform and perspective projection of one world point per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_we/cfg_index/cfg_wdata write camera position, yaw and
//   pitch cosine/sine pairs, focal scale and screen center. Write only while
//   no point is in flight.
//   Input: a point is taken on each clock where start is high and busy is
//   low. busy never rises, so a point may enter every cycle.
//   Output: out_valid strobes for one cycle with screen_x, screen_y, culled.
//   Results come back in input order, one per point.
//   Stages in order: offset, yaw and pitch rotations, magnitude/near
//   test, the multiply and the one-bit-a-stage divider, final add and
//   clamp. Throughput: one point per cycle.
//   Reset: synchronous, clears all in-flight beats and restores the
//   register defaults. The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module perspective_point_projection import ppp_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_DEF,
  parameter int TRIG_FRAC_BITS  = TRIG_FRAC_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                cfg_wdata,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [COORD_W-1:0]  in_point_x,
  input  logic signed [COORD_W-1:0]  in_point_y,
  input  logic signed [COORD_W-1:0]  in_point_z,
  output logic                       out_valid,
  output logic signed [COORD_W-1:0]  out_screen_x,
  output logic signed [COORD_W-1:0]  out_screen_y,
  output logic                       out_culled
);

  localparam int DW   = COORD_W + 1;
  localparam int XW   = DW + TRIG_W + 1 - TRIG_FRAC_BITS;
  localparam int YW   = XW + TRIG_W + 1 - TRIG_FRAC_BITS;
  localparam int DLAT = QCAP_BITS + 3;
  localparam int LAT  = DLAT + 7;
  localparam int SW   = QCAP_BITS + 3;

  localparam logic signed [YW+3:0] NEAR_LIM = (YW+4)'(1) <<< COORD_FRAC_BITS;
  localparam logic signed [63:0]   CULL64   = -(64'sd1000 <<< COORD_FRAC_BITS);
  localparam logic [31:0]          CULL_VAL =
    (CULL64 < -64'sd2147483648) ? 32'h8000_0000 : CULL64[31:0];
  localparam logic signed [SW-1:0] SAT_HI   = SW'(32'h7fff_ffff);
  localparam logic signed [SW-1:0] SAT_LO   = -SAT_HI - SW'(1);

  // configuration registers
  logic [31:0]          cam_x_r, cam_y_r, cam_z_r, yaw_r, pitch_r;
  logic [FOCAL_W-1:0]   focal_r;
  logic [CENTER_W-1:0]  ctr_x_r, ctr_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
      yaw_r   <= RST_TRIG;
      pitch_r <= RST_TRIG;
      focal_r <= RST_FOCAL;
      ctr_x_r <= RST_CTR_X;
      ctr_y_r <= RST_CTR_Y;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAMERA_X:    cam_x_r <= cfg_wdata;
        REG_CAMERA_Y:    cam_y_r <= cfg_wdata;
        REG_CAMERA_Z:    cam_z_r <= cfg_wdata;
        REG_YAW_TRIG:    yaw_r   <= cfg_wdata;
        REG_PITCH_TRIG:  pitch_r <= cfg_wdata;
        REG_FOCAL_SCALE: focal_r <= cfg_wdata;
        REG_CENTER_X:    ctr_x_r <= cfg_wdata[CENTER_W-1:0];
        REG_CENTER_Y:    ctr_y_r <= cfg_wdata[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: offset from camera
  logic                 v1_r;
  logic signed [DW-1:0] dx_r, dy_r, dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= {in_point_x[COORD_W-1], in_point_x} - {cam_x_r[31], cam_x_r};
    dy_r <= {in_point_y[COORD_W-1], in_point_y} - {cam_y_r[31], cam_y_r};
    dz_r <= {in_point_z[COORD_W-1], in_point_z} - {cam_z_r[31], cam_z_r};
  end

  // yaw rotation in x-z
  logic                 v3;
  logic signed [XW-1:0] rx, rzt;
  logic signed [DW-1:0] dy_d_r [0:1];

  ppp_rotate #(.AW(DW), .TF(TRIG_FRAC_BITS)) u_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1_r),
    .in_a      (dx_r),
    .in_b      (dz_r),
    .in_cos    (yaw_r[31:16]),
    .in_sin    (yaw_r[15:0]),
    .out_valid (v3),
    .out_a     (rx),
    .out_b     (rzt)
  );

  always_ff @(posedge clk) begin
    dy_d_r[0] <= dy_r;
    dy_d_r[1] <= dy_d_r[0];
  end

  // pitch rotation in y-z
  logic                 v5;
  logic signed [YW-1:0] ry, rz;
  logic signed [XW-1:0] dy_ext;
  logic signed [XW-1:0] x_d_r [0:1];

  assign dy_ext = {{(XW-DW){dy_d_r[1][DW-1]}}, dy_d_r[1]};

  ppp_rotate #(.AW(XW), .TF(TRIG_FRAC_BITS)) u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3),
    .in_a      (dy_ext),
    .in_b      (rzt),
    .in_cos    (pitch_r[31:16]),
    .in_sin    (pitch_r[15:0]),
    .out_valid (v5),
    .out_a     (ry),
    .out_b     (rz)
  );

  always_ff @(posedge clk) begin
    x_d_r[0] <= rx;
    x_d_r[1] <= x_d_r[0];
  end

  // stage 6: magnitudes and near-plane test
  logic                 v6_r;
  logic [XW-1:0]        mag_x_nxt, mag_x_r;
  logic [YW-1:0]        mag_y_nxt, mag_y_r, z_r;
  logic signed [YW+3:0] zx, z10;
  logic [2:0]           side_nxt;
  logic [2:0]           side_r [0:DLAT];

  always_comb begin
    mag_x_nxt = x_d_r[1][XW-1] ? XW'(-x_d_r[1]) : XW'(x_d_r[1]);
    mag_y_nxt = ry[YW-1] ? YW'(-ry) : YW'(ry);
    zx        = {{4{rz[YW-1]}}, rz};
    z10       = (zx <<< 3) + (zx <<< 1);
    // {culled, x negative, y negative}
    side_nxt  = {(z10 < NEAR_LIM), x_d_r[1][XW-1], ry[YW-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5;
    end
  end

  always_ff @(posedge clk) begin
    mag_x_r   <= mag_x_nxt;
    mag_y_r   <= mag_y_nxt;
    z_r       <= rz;
    side_r[0] <= side_nxt;
    for (int k = 1; k <= DLAT; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  // scaled quotients
  logic                 vqx, vqy, vq;
  logic [QCAP_BITS:0]   qx, qy;

  ppp_proj_div #(.MW(XW), .NW(YW)) u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v6_r),
    .in_mag    (mag_x_r),
    .in_scale  (focal_r),
    .in_den    (z_r),
    .out_valid (vqx),
    .out_quot  (qx)
  );

  ppp_proj_div #(.MW(YW), .NW(YW)) u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v6_r),
    .in_mag    (mag_y_r),
    .in_scale  (focal_r),
    .in_den    (z_r),
    .out_valid (vqy),
    .out_quot  (qy)
  );

  assign vq = vqx & vqy;

  // final: center offset, clamp, cull select
  logic signed [SW-1:0] qxs, qys, cxs, cys, sx, sy;
  logic [31:0]          sx_nxt, sy_nxt;
  logic                 ov_r, oc_r;
  logic [31:0]          osx_r, osy_r;

  always_comb begin
    qxs = SW'(qx);
    qys = SW'(qy);
    cxs = SW'(ctr_x_r);
    cys = SW'(ctr_y_r);
    sx  = side_r[DLAT][1] ? (cxs - qxs) : (cxs + qxs);
    sy  = side_r[DLAT][0] ? (cys + qys) : (cys - qys);
    if (side_r[DLAT][2]) begin
      sx_nxt = CULL_VAL;
      sy_nxt = CULL_VAL;
    end else begin
      sx_nxt = (sx > SAT_HI) ? 32'h7fff_ffff :
               (sx < SAT_LO) ? 32'h8000_0000 : sx[31:0];
      sy_nxt = (sy > SAT_HI) ? 32'h7fff_ffff :
               (sy < SAT_LO) ? 32'h8000_0000 : sy[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= vq;
    end
  end

  always_ff @(posedge clk) begin
    oc_r  <= side_r[DLAT][2];
    osx_r <= sx_nxt;
    osy_r <= sy_nxt;
  end

  assign out_valid    = ov_r;
  assign out_culled   = oc_r;
  assign out_screen_x = osx_r;
  assign out_screen_y = osy_r;

`ifndef SYNTH
  // every accepted point produces a result
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted point did not produce a result");

  // no result without a matching accepted point
  a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without matching point");

  // culled results carry the fixed marker coordinates
  a_cull: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_culled) |->
      (out_screen_x == CULL_VAL && out_screen_y == CULL_VAL))
    else $error("culled result with wrong coordinates");
`endif

endmodule

### sim/tb_perspective_point_projection.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_perspective_point_projection
// Drives world points through the projection pipeline under several camera
// setups and idle patterns, predicts each screen position in the bench and
// compares every output beat in order.
// ----------------------------------------------------------------------------
module tb_perspective_point_projection import ppp_pkg::*; ();

  localparam int CFRAC = COORD_FRAC_DEF;
  localparam int TFRAC = TRIG_FRAC_DEF;
  localparam int LATENCY = 50;
  localparam longint CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic               culled;
  } screen_pt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic out_valid;
  logic signed [31:0] out_screen_x, out_screen_y;
  logic out_culled;

  // camera copy kept by the bench
  logic signed [31:0] cam_x, cam_y, cam_z;
  logic [31:0] yaw_cs, pitch_cs, focal;
  logic [30:0] ctr_x, ctr_y;

  screen_pt_t expected_q[$];
  int  n_errors = 0;
  int  idle_pct = 0;
  longint cycle_cnt = 0;

  perspective_point_projection i_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .start, .busy,
    .in_point_x, .in_point_y, .in_point_z,
    .out_valid, .out_screen_x, .out_screen_y, .out_culled
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // floor division by 2^n on a signed value
  function automatic longint floor_div_pow2(input longint v, input int n);
    return v >>> n;
  endfunction

  // min(floor(mag*scale/den), 2^40)
  function automatic longint capped_quot(input longint mag, input longint scale,
                                         input longint den);
    logic [127:0] prod;
    logic [127:0] q;
    prod = 128'(mag) * 128'(scale);
    q = prod / 128'(den);
    if (q > (128'd1 << QCAP_BITS)) q = 128'd1 << QCAP_BITS;
    return longint'(q[63:0]);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic screen_pt_t project_point(input logic signed [31:0] px,
      input logic signed [31:0] py, input logic signed [31:0] pz);
    longint dx, dy, dz, cyw, syw, cpt, spt, rx, ry, rz, zt, qx, qy;
    screen_pt_t r;
    dx = longint'(px) - longint'(cam_x);
    dy = longint'(py) - longint'(cam_y);
    dz = longint'(pz) - longint'(cam_z);
    cyw = longint'($signed(yaw_cs[31:16]));
    syw = longint'($signed(yaw_cs[15:0]));
    cpt = longint'($signed(pitch_cs[31:16]));
    spt = longint'($signed(pitch_cs[15:0]));
    rx = floor_div_pow2(dx * cyw - dz * syw, TFRAC);
    zt = floor_div_pow2(dx * syw + dz * cyw, TFRAC);
    ry = floor_div_pow2(dy * cpt - zt * spt, TFRAC);
    rz = floor_div_pow2(dy * spt + zt * cpt, TFRAC);
    if (rz * 10 < (64'sd1 <<< CFRAC)) begin
      r.sx = 32'(clamp32(-(64'sd1000 <<< CFRAC)));
      r.sy = r.sx;
      r.culled = 1'b1;
      return r;
    end
    qx = capped_quot(rx < 0 ? -rx : rx, longint'(focal), rz);
    qy = capped_quot(ry < 0 ? -ry : ry, longint'(focal), rz);
    r.sx = 32'(clamp32(longint'(ctr_x) + (rx < 0 ? -qx : qx)));
    r.sy = 32'(clamp32(longint'(ctr_y) - (ry < 0 ? -qy : qy)));
    r.culled = 1'b0;
    return r;
  endfunction

  // output beat checker
  always @(posedge clk) begin
    screen_pt_t want;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", 64'(out_screen_x), '0);
      end else begin
        want = expected_q.pop_front();
        if (out_screen_x !== want.sx) report_mismatch("screen_x", out_screen_x, want.sx);
        if (out_screen_y !== want.sy) report_mismatch("screen_y", out_screen_y, want.sy);
        if (out_culled !== want.culled) report_mismatch("culled", out_culled, want.culled);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CAMERA_X:    cam_x = val;
      REG_CAMERA_Y:    cam_y = val;
      REG_CAMERA_Z:    cam_z = val;
      REG_YAW_TRIG:    yaw_cs = val;
      REG_PITCH_TRIG:  pitch_cs = val;
      REG_FOCAL_SCALE: focal = val;
      REG_CENTER_X:    ctr_x = val[30:0];
      default:         ctr_y = val[30:0];
    endcase
  endtask

  // wait until the pipe is empty, then flush
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // one point beat; start is held across back-to-back beats
  task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
                            input logic signed [31:0] pz);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(project_point(px, py, pz));
  endtask

  function automatic logic [31:0] rand_trig();
    real a;
    logic signed [15:0] c, s;
    a = $urandom_range(0, 6283) / 1000.0;
    c = 16'($rtoi($cos(a) * 16384.0));
    s = 16'($rtoi($sin(a) * 16384.0));
    return {c, s};
  endfunction

  // small coordinates around the camera, mostly ahead in z, with occasional full-range noise
  task automatic random_points(input int n, input int pct);
    logic signed [31:0] px, py, pz;
    idle_pct = pct;
    repeat (n) begin
      if ($urandom_range(9) == 0) begin
        px = $urandom; py = $urandom; pz = $urandom;
      end else begin
        px = cam_x + $signed(32'($urandom_range(0, 32'h0140_0000)) - 32'h00A0_0000);
        py = cam_y + $signed(32'($urandom_range(0, 32'h0140_0000)) - 32'h00A0_0000);
        pz = cam_z + $signed(32'($urandom_range(0, 32'h0200_0000)) - 32'h0040_0000);
      end
      send_point(px, py, pz);
    end
    drain();
  endtask

  task automatic test_directed();
    idle_pct = 0;
    send_point(0, 0, 32'sh0001_0000);
    send_point(0, 0, 0);
    send_point(0, 0, 32'sd6553);
    send_point(0, 0, 32'sd6554);
    send_point(32'sh0001_0000, 32'sh0001_0000, 32'sd6554);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sd6554);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sd6554);
    send_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    send_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    send_point(32'shffff_ffff, 32'shffff_ffff, 32'sh0010_0000);
    send_point(-32'sh0003_0000, 32'sh0002_0000, 32'sh0005_0000);
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_CAMERA_X, 32'h8000_0000);
    write_reg(REG_CAMERA_Y, 32'h7fff_ffff);
    write_reg(REG_CAMERA_Z, 32'h8000_0000);
    write_reg(REG_YAW_TRIG, 32'h8000_8000);
    write_reg(REG_PITCH_TRIG, 32'h7fff_7fff);
    write_reg(REG_FOCAL_SCALE, 32'hffff_ffff);
    write_reg(REG_CENTER_X, 32'hffff_ffff);
    write_reg(REG_CENTER_Y, 32'h0);
    idle_pct = 0;
    send_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    send_point(0, 0, 0);
    send_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    random_points(200, 19);
    write_reg(REG_FOCAL_SCALE, 32'h0);
    write_reg(REG_CENTER_X, 32'h0);
    write_reg(REG_CENTER_Y, 32'h7fff_ffff);
    write_reg(REG_YAW_TRIG, 32'h0000_0000);
    random_points(100, 0);
  endtask

  task automatic test_random_cameras();
    int pcts[4] = '{0, 66, 0, 19};
    foreach (pcts[k]) begin
      write_reg(REG_CAMERA_X, $urandom_range(0, 32'h0200_0000) - 32'h0100_0000);
      write_reg(REG_CAMERA_Y, $urandom_range(0, 32'h0200_0000) - 32'h0100_0000);
      write_reg(REG_CAMERA_Z, $urandom_range(0, 32'h0200_0000) - 32'h0100_0000);
      write_reg(REG_YAW_TRIG, rand_trig());
      write_reg(REG_PITCH_TRIG, (k == 0) ? RST_TRIG : rand_trig());
      write_reg(REG_FOCAL_SCALE, (k == 0) ? RST_FOCAL : $urandom);
      write_reg(REG_CENTER_X, $urandom);
      write_reg(REG_CENTER_Y, $urandom);
      random_points(425, pcts[k]);
    end
  endtask

  initial begin
    cam_x = 0; cam_y = 0; cam_z = 0;
    yaw_cs = RST_TRIG; pitch_cs = RST_TRIG; focal = RST_FOCAL;
    ctr_x = RST_CTR_X; ctr_y = RST_CTR_Y;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_register_extremes();
    test_random_cameras();
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
